### hdl/cau_pkg.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Types, opcodes, status codes and the arithmetic helpers of the datapath; the checker uses the status codes.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int QUO_W     = 33;                    // quotient bits kept before rounding
   localparam int NUM_W     = 64 + FRAC_BITS + 1;    // numerator scaled for round-to-nearest
   localparam int CMP_W     = 64 + DATA_W - FRAC_BITS;

   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_CDIV = 3'd3,
      OP_CONJ = 3'd4,
      OP_RDIV = 3'd5
   } op_type;

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_DZ  = 2'd1;
   localparam logic [1:0] ST_OVF = 2'd2;

   typedef struct packed {
      logic [DATA_W-1:0] val;
      logic              ovf;
   } pack_type;

   typedef struct packed {
      logic             neg;
      logic             big;
      logic [63:0]      rem;
      logic [QUO_W-1:0] low;
      logic [QUO_W-1:0] quo;
   } lane_type;

   typedef struct packed {
      logic              is_div;
      logic              dz;
      logic [DATA_W-1:0] dir_re;
      logic [DATA_W-1:0] dir_im;
      logic              dir_ovf;
      logic [63:0]       d;
      lane_type          lane_re;
      lane_type          lane_im;
   } dstage_type;

   // Saturate a sign/magnitude value into a signed word.
   function automatic pack_type pack_mag(input logic neg, input logic [64:0] mag);
      pack_type p;
      p.ovf = 1'b0;
      if (!neg) begin
         if (mag > 65'({1'b0, {(DATA_W-1){1'b1}}})) begin
            p.val = {1'b0, {(DATA_W-1){1'b1}}};
            p.ovf = 1'b1;
         end else begin
            p.val = mag[DATA_W-1:0];
         end
      end else begin
         if (mag > 65'({1'b1, {(DATA_W-1){1'b0}}})) begin
            p.val = {1'b1, {(DATA_W-1){1'b0}}};
            p.ovf = 1'b1;
         end else begin
            p.val = (~mag[DATA_W-1:0]) + DATA_W'(1);
         end
      end
      return p;
   endfunction

   function automatic pack_type pack_sum(input logic signed [DATA_W:0] v);
      logic [DATA_W+1:0] ext;
      logic [DATA_W+1:0] absv;
      ext  = {v[DATA_W], v};
      absv = v[DATA_W] ? (~ext) + (DATA_W+2)'(1) : ext;
      return pack_mag(v[DATA_W], 65'(absv[DATA_W:0]));
   endfunction

   // Set up a lane for n * 2^(FRAC_BITS+1) / d, flag quotients too big for QUO_W bits.
   function automatic lane_type lane_init(input logic neg, input logic [63:0] n,
                                          input logic [63:0] d);
      lane_type         l;
      logic [NUM_W-1:0] num;
      logic [CMP_W-1:0] lhs;
      num   = NUM_W'(n) << (FRAC_BITS + 1);
      lhs   = CMP_W'(n);
      l.neg = neg;
      l.big = lhs >= (CMP_W'(d) << (DATA_W - FRAC_BITS));
      l.rem = {{(64-(NUM_W-QUO_W)){1'b0}}, num[NUM_W-1:QUO_W]};
      l.low = num[QUO_W-1:0];
      l.quo = '0;
      return l;
   endfunction

   function automatic lane_type div_step(input lane_type l, input logic [63:0] d);
      lane_type    o;
      logic [64:0] r2;
      logic [64:0] diff;
      r2   = {l.rem, l.low[QUO_W-1]};
      diff = r2 - {1'b0, d};
      o    = l;
      if (r2 >= {1'b0, d}) begin
         o.rem = diff[63:0];
         o.quo = {l.quo[QUO_W-2:0], 1'b1};
      end else begin
         o.rem = r2[63:0];
         o.quo = {l.quo[QUO_W-2:0], 1'b0};
      end
      o.low = {l.low[QUO_W-2:0], 1'b0};
      return o;
   endfunction

   // Round half away from zero on the doubled quotient, then saturate.
   function automatic pack_type div_final(input lane_type l);
      logic [QUO_W:0] rnd;
      rnd = ({1'b0, l.quo} + (QUO_W+1)'(1)) >> 1;
      if (l.big) begin
         return pack_mag(l.neg, 65'(1) << DATA_W);
      end
      return pack_mag(l.neg, 65'(rnd));
   endfunction

endpackage

### hdl/complex_arithmetic_unit.sv
// A request passes the capture, product, sum, divider-operand, divider and response registers in order.
// Throughput: one request per cycle; a held result stalls the whole pipeline.
// The depth comes from the 33-stage restoring divider, one quotient bit a stage.
// Reset: synchronous, active high; clears all stage valid bits, no data is lost
// other than requests still in flight.
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Pipelined Q16.16 complex add, subtract, multiply, conjugate, complex divide and divide by the real part of b.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit
   import cau_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [2:0]               req_opcode,
   input  logic signed [DATA_W-1:0] req_a_re,
   input  logic signed [DATA_W-1:0] req_a_im,
   input  logic signed [DATA_W-1:0] req_b_re,
   input  logic signed [DATA_W-1:0] req_b_im,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_res_re,
   output logic signed [DATA_W-1:0] rsp_res_im,
   output logic [1:0]               rsp_status
);

   logic advance;

   // stage 0: captured request
   logic                     v0_ff;
   logic [2:0]               op0_ff;
   logic signed [DATA_W-1:0] ar0_ff, ai0_ff, br0_ff, bi0_ff;

   // stage 1: products and simple results
   logic                     v1_ff;
   logic [2:0]               op1_ff;
   logic signed [DATA_W-1:0] ar1_ff, ai1_ff, br1_ff;
   logic signed [63:0]       arbr_ff, aibi_ff, arbi_ff, aibr_ff, brbr_ff, bibi_ff;
   pack_type                 dre1_ff, dim1_ff;
   pack_type                 dre1_in, dim1_in;

   // stage 2: sums
   logic                     v2_ff;
   logic [2:0]               op2_ff;
   logic signed [DATA_W-1:0] ar2_ff, ai2_ff, br2_ff;
   logic signed [64:0]       pr2_ff, pi2_ff;
   logic signed [64:0]       pr2_in, pi2_in;
   logic [63:0]              den2_ff;
   pack_type                 dre2_ff, dim2_ff;

   // stage 3: divider operands and multiply result
   logic                     v3_ff;
   logic                     isdiv3_ff, dz3_ff;
   logic                     nre3_ff, nim3_ff;
   logic [63:0]              mre3_ff, mim3_ff, d3_ff;
   pack_type                 dre3_ff, dim3_ff;
   logic                     isdiv3_in, dz3_in, nre3_in, nim3_in;
   logic [63:0]              mre3_in, mim3_in, d3_in;
   pack_type                 dre3_in, dim3_in;

   // divider stages
   logic                     dv_ff [0:QUO_W];
   dstage_type               ds_ff [0:QUO_W];
   dstage_type               ds0_in;

   pack_type                 fre_in, fim_in;
   logic [DATA_W-1:0]        rre_in, rim_in;
   logic [1:0]               rst_in;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= req_valid;
      end
      if (advance) begin
         op0_ff <= req_opcode;
         ar0_ff <= req_a_re;
         ai0_ff <= req_a_im;
         br0_ff <= req_b_re;
         bi0_ff <= req_b_im;
      end
   end

   always_comb begin
      dre1_in = '0;
      dim1_in = '0;
      case (op0_ff)
         OP_ADD: begin
            dre1_in = pack_sum({ar0_ff[DATA_W-1], ar0_ff} + {br0_ff[DATA_W-1], br0_ff});
            dim1_in = pack_sum({ai0_ff[DATA_W-1], ai0_ff} + {bi0_ff[DATA_W-1], bi0_ff});
         end
         OP_SUB: begin
            dre1_in = pack_sum({ar0_ff[DATA_W-1], ar0_ff} - {br0_ff[DATA_W-1], br0_ff});
            dim1_in = pack_sum({ai0_ff[DATA_W-1], ai0_ff} - {bi0_ff[DATA_W-1], bi0_ff});
         end
         OP_CONJ: begin
            dre1_in = pack_sum({ar0_ff[DATA_W-1], ar0_ff});
            dim1_in = pack_sum(-{ai0_ff[DATA_W-1], ai0_ff});
         end
         default: begin
            dre1_in = '0;
            dim1_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= v0_ff;
      end
      if (advance) begin
         op1_ff  <= op0_ff;
         ar1_ff  <= ar0_ff;
         ai1_ff  <= ai0_ff;
         br1_ff  <= br0_ff;
         arbr_ff <= ar0_ff * br0_ff;
         aibi_ff <= ai0_ff * bi0_ff;
         arbi_ff <= ar0_ff * bi0_ff;
         aibr_ff <= ai0_ff * br0_ff;
         brbr_ff <= br0_ff * br0_ff;
         bibi_ff <= bi0_ff * bi0_ff;
         dre1_ff <= dre1_in;
         dim1_ff <= dim1_in;
      end
   end

   always_comb begin
      if (op1_ff == OP_MUL) begin
         pr2_in = {arbr_ff[63], arbr_ff} - {aibi_ff[63], aibi_ff};
         pi2_in = {arbi_ff[63], arbi_ff} + {aibr_ff[63], aibr_ff};
      end else begin
         pr2_in = {arbr_ff[63], arbr_ff} + {aibi_ff[63], aibi_ff};
         pi2_in = {aibr_ff[63], aibr_ff} - {arbi_ff[63], arbi_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
      if (advance) begin
         op2_ff  <= op1_ff;
         ar2_ff  <= ar1_ff;
         ai2_ff  <= ai1_ff;
         br2_ff  <= br1_ff;
         pr2_ff  <= pr2_in;
         pi2_ff  <= pi2_in;
         den2_ff <= $unsigned(brbr_ff) + $unsigned(bibi_ff);
         dre2_ff <= dre1_ff;
         dim2_ff <= dim1_ff;
      end
   end

   always_comb begin
      logic [64:0]     abs_re;
      logic [64:0]     abs_im;
      logic [DATA_W:0] abs_ar;
      logic [DATA_W:0] abs_ai;
      logic [DATA_W:0] abs_br;
      abs_re = pr2_ff[64] ? -pr2_ff : pr2_ff;
      abs_im = pi2_ff[64] ? -pi2_ff : pi2_ff;
      abs_ar = ar2_ff[DATA_W-1] ? -{ar2_ff[DATA_W-1], ar2_ff} : {ar2_ff[DATA_W-1], ar2_ff};
      abs_ai = ai2_ff[DATA_W-1] ? -{ai2_ff[DATA_W-1], ai2_ff} : {ai2_ff[DATA_W-1], ai2_ff};
      abs_br = br2_ff[DATA_W-1] ? -{br2_ff[DATA_W-1], br2_ff} : {br2_ff[DATA_W-1], br2_ff};
      isdiv3_in = 1'b0;
      dz3_in    = 1'b0;
      nre3_in   = pr2_ff[64];
      nim3_in   = pi2_ff[64];
      mre3_in   = abs_re[63:0];
      mim3_in   = abs_im[63:0];
      d3_in     = den2_ff;
      dre3_in   = dre2_ff;
      dim3_in   = dim2_ff;
      unique case (op2_ff)
         OP_MUL: begin
            dre3_in = pack_mag(pr2_ff[64], 65'(abs_re[63:0] >> FRAC_BITS)
                               + 65'(abs_re[FRAC_BITS-1]));
            dim3_in = pack_mag(pi2_ff[64], 65'(abs_im[63:0] >> FRAC_BITS)
                               + 65'(abs_im[FRAC_BITS-1]));
         end
         OP_CDIV: begin
            isdiv3_in = 1'b1;
            dz3_in    = den2_ff == 64'd0;
         end
         OP_RDIV: begin
            isdiv3_in = 1'b1;
            dz3_in    = br2_ff == '0;
            nre3_in   = (ar2_ff[DATA_W-1] != br2_ff[DATA_W-1]) && (ar2_ff != '0);
            nim3_in   = (ai2_ff[DATA_W-1] != br2_ff[DATA_W-1]) && (ai2_ff != '0);
            mre3_in   = 64'(abs_ar);
            mim3_in   = 64'(abs_ai);
            d3_in     = 64'(abs_br);
         end
         default: begin
            isdiv3_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
      if (advance) begin
         isdiv3_ff <= isdiv3_in;
         dz3_ff    <= dz3_in;
         nre3_ff   <= nre3_in;
         nim3_ff   <= nim3_in;
         mre3_ff   <= mre3_in;
         mim3_ff   <= mim3_in;
         d3_ff     <= d3_in;
         dre3_ff   <= dre3_in;
         dim3_ff   <= dim3_in;
      end
   end

   always_comb begin
      ds0_in.is_div  = isdiv3_ff;
      ds0_in.dz      = dz3_ff;
      ds0_in.dir_re  = dre3_ff.val;
      ds0_in.dir_im  = dim3_ff.val;
      ds0_in.dir_ovf = dre3_ff.ovf | dim3_ff.ovf;
      ds0_in.d       = d3_ff;
      ds0_in.lane_re = lane_init(nre3_ff, mre3_ff, d3_ff);
      ds0_in.lane_im = lane_init(nim3_ff, mim3_ff, d3_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (advance) begin
         dv_ff[0] <= v3_ff;
      end
      if (advance) begin
         ds_ff[0] <= ds0_in;
      end
   end

   for (genvar k = 1; k <= QUO_W; k++) begin : g_div
      dstage_type step_in;
      always_comb begin
         step_in         = ds_ff[k-1];
         step_in.lane_re = div_step(ds_ff[k-1].lane_re, ds_ff[k-1].d);
         step_in.lane_im = div_step(ds_ff[k-1].lane_im, ds_ff[k-1].d);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k] <= 1'b0;
         end else if (advance) begin
            dv_ff[k] <= dv_ff[k-1];
         end
         if (advance) begin
            ds_ff[k] <= step_in;
         end
      end
   end

   always_comb begin
      fre_in = div_final(ds_ff[QUO_W].lane_re);
      fim_in = div_final(ds_ff[QUO_W].lane_im);
      if (ds_ff[QUO_W].is_div && ds_ff[QUO_W].dz) begin
         rre_in = '0;
         rim_in = '0;
         rst_in = ST_DZ;
      end else if (ds_ff[QUO_W].is_div) begin
         rre_in = fre_in.val;
         rim_in = fim_in.val;
         rst_in = (fre_in.ovf | fim_in.ovf) ? ST_OVF : ST_OK;
      end else begin
         rre_in = ds_ff[QUO_W].dir_re;
         rim_in = ds_ff[QUO_W].dir_im;
         rst_in = ds_ff[QUO_W].dir_ovf ? ST_OVF : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (advance) begin
         rsp_valid <= dv_ff[QUO_W];
      end
      if (advance) begin
         rsp_res_re <= rre_in;
         rsp_res_im <= rim_in;
         rsp_status <= rst_in;
      end
   end

endmodule

### hdl/cau_checker.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit checker
// Port-level properties of the unit, bound into complex_arithmetic_unit.
// ----------------------------------------------------------------------------
module cau_checker
   import cau_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic signed [DATA_W-1:0] rsp_res_re,
   input logic signed [DATA_W-1:0] rsp_res_im,
   input logic [1:0]               rsp_status
);

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_DZ || rsp_status == ST_OVF))
      else $error("unknown status code");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_DZ) |-> (rsp_res_re == '0 && rsp_res_im == '0))
      else $error("divide by zero result not cleared");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall does not follow held response");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_res_re)
                                    && $stable(rsp_res_im) && $stable(rsp_status)))
      else $error("held response changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
   .clock      (clock),
   .reset      (reset),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_res_re (rsp_res_re),
   .rsp_res_im (rsp_res_im),
   .rsp_status (rsp_status)
);
